FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker of the tokenizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define JBT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define JBT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: hw/rtl/jbt_pkg.sv
// Types, codes and keyword tables of the JSON byte tokenizer.
`default_nettype none

package jbt_pkg;

	localparam int unsigned POS_BITS_DEF   = 32;
	localparam int unsigned LINE_BITS_DEF  = 32;
	localparam int unsigned RES_FIFO_DEPTH = 4;

	typedef enum logic [3:0] {
		TK_LBRACE  = 4'd0,
		TK_RBRACE  = 4'd1,
		TK_LSQUARE = 4'd2,
		TK_RSQUARE = 4'd3,
		TK_STRING  = 4'd4,
		TK_NUMBER  = 4'd5,
		TK_TRUE    = 4'd6,
		TK_FALSE   = 4'd7,
		TK_NULL    = 4'd8,
		TK_COMMA   = 4'd9,
		TK_COLON   = 4'd10,
		TK_END     = 4'd11
	} kind_t;

	typedef enum logic [1:0] {
		ERR_EOF_STRING = 2'd0,
		ERR_DIGIT      = 2'd1,
		ERR_KEYWORD    = 2'd2,
		ERR_UNEXPECTED = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		KW_TRUE  = 2'd0,
		KW_FALSE = 2'd1,
		KW_NULL  = 2'd2
	} kw_t;

	typedef enum logic [9:0] {
		M_IDLE = 10'b00_0000_0001,
		M_STR  = 10'b00_0000_0010,
		M_ESC  = 10'b00_0000_0100,
		M_SIGN = 10'b00_0000_1000,
		M_ZERO = 10'b00_0001_0000,
		M_INT  = 10'b00_0010_0000,
		M_FRAC = 10'b00_0100_0000,
		M_EXP  = 10'b00_1000_0000,
		M_EXPD = 10'b01_0000_0000,
		M_KEY  = 10'b10_0000_0000
	} mode_t;

	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_LSQUARE = 8'h5B;
	localparam logic [7:0] CH_RSQUARE = 8'h5D;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_ONE     = 8'h31;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOW_E   = 8'h65;
	localparam logic [7:0] CH_UP_E    = 8'h45;
	localparam logic [7:0] CH_LOW_T   = 8'h74;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_LOW_N   = 8'h6E;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_FF      = 8'h0C;
	localparam logic [7:0] CH_LF      = 8'h0A;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_input;
	} item_t;

	typedef struct packed {
		kind_t       token_kind;
		logic        is_error;
		err_t        error_code;
		logic [31:0] start_pos;
		logic [31:0] end_pos;
		logic [31:0] line_number;
		logic        last_of_run;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} lex_out_t;

	function automatic logic [2:0] kw_len(input kw_t sel);
		case (sel)
			KW_FALSE: kw_len = 3'd5;
			default:  kw_len = 3'd4;
		endcase
	endfunction

	function automatic kind_t kw_kind(input kw_t sel);
		case (sel)
			KW_TRUE:  kw_kind = TK_TRUE;
			KW_FALSE: kw_kind = TK_FALSE;
			default:  kw_kind = TK_NULL;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input kw_t sel, input logic [2:0] idx);
		logic [7:0] ch;
		ch = 8'h00;
		case (sel)
			KW_TRUE: begin
				case (idx)
					3'd0:    ch = "t";
					3'd1:    ch = "r";
					3'd2:    ch = "u";
					3'd3:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			KW_FALSE: begin
				case (idx)
					3'd0:    ch = "f";
					3'd1:    ch = "a";
					3'd2:    ch = "l";
					3'd3:    ch = "s";
					3'd4:    ch = "e";
					default: ch = 8'h00;
				endcase
			end
			default: begin
				case (idx)
					3'd0:    ch = "n";
					3'd1:    ch = "u";
					3'd2:    ch = "l";
					3'd3:    ch = "l";
					default: ch = 8'h00;
				endcase
			end
		endcase
		return ch;
	endfunction

	function automatic result_t make_token(input kind_t kind, input logic [31:0] s,
			input logic [31:0] e, input logic [31:0] ln);
		result_t r;
		r.token_kind  = kind;
		r.is_error    = 1'b0;
		r.error_code  = ERR_EOF_STRING;
		r.start_pos   = s;
		r.end_pos     = e;
		r.line_number = ln;
		r.last_of_run = 1'b0;
		return r;
	endfunction

	function automatic result_t make_error(input err_t code, input logic [31:0] s,
			input logic [31:0] e, input logic [31:0] ln);
		result_t r;
		r.token_kind  = TK_LBRACE;
		r.is_error    = 1'b1;
		r.error_code  = code;
		r.start_pos   = s;
		r.end_pos     = e;
		r.line_number = ln;
		r.last_of_run = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/jbt_chan_if.sv
// Valid/ready channel interface that carries one request per handshake.
`default_nettype none

interface jbt_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/jbt_lex_core.sv
// Lexer state and the combinational logic that turns one byte into up to two results.
`default_nettype none

module jbt_lex_core import jbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = POS_BITS_DEF,
	parameter int unsigned LINE_BITS     = LINE_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  item_t    item,
	output lex_out_t res
);

	mode_t                    mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [LINE_BITS-1:0]     line_q;
	logic [POSITION_BITS-1:0] tstart_q;
	logic [LINE_BITS-1:0]     tline_q;
	kw_t                      ksel_q;
	logic [2:0]               klet_q;
	logic                     halt_q;

	mode_t                    n_mode;
	logic [POSITION_BITS-1:0] n_pos;
	logic [LINE_BITS-1:0]     n_line;
	logic [POSITION_BITS-1:0] n_tstart;
	logic [LINE_BITS-1:0]     n_tline;
	kw_t                      n_ksel;
	logic [2:0]               n_klet;
	logic                     n_halt;

	logic [7:0]  c;
	logic        digit;
	logic [31:0] pos32, line32, tstart32, tline32, prev32;

	logic    id_emit, id_nl, id_fail;
	result_t id_res;
	mode_t   id_mode;
	kw_t     id_ksel;
	logic [2:0] id_klet;

	result_t    r0, r1;
	logic [1:0] cnt;
	logic       use_idle;
	logic [2:0] klet_inc;

	assign c        = item.text_byte;
	assign digit    = (c >= CH_ZERO) && (c <= CH_NINE);
	assign pos32    = 32'(pos_q);
	assign line32   = 32'(line_q);
	assign tstart32 = 32'(tstart_q);
	assign tline32  = 32'(tline_q);
	assign prev32   = 32'((pos_q == '0) ? pos_q : pos_q - POSITION_BITS'(1));
	assign klet_inc = klet_q + 3'd1;

	always_comb begin
		id_emit = 1'b0;
		id_nl   = 1'b0;
		id_fail = 1'b0;
		id_res  = make_token(TK_LBRACE, pos32, pos32, line32);
		id_mode = M_IDLE;
		id_ksel = ksel_q;
		id_klet = klet_q;
		case (c)
			CH_LBRACE: id_emit = 1'b1;
			CH_RBRACE: begin
				id_emit = 1'b1;
				id_res.token_kind = TK_RBRACE;
			end
			CH_LSQUARE: begin
				id_emit = 1'b1;
				id_res.token_kind = TK_LSQUARE;
			end
			CH_RSQUARE: begin
				id_emit = 1'b1;
				id_res.token_kind = TK_RSQUARE;
			end
			CH_COMMA: begin
				id_emit = 1'b1;
				id_res.token_kind = TK_COMMA;
			end
			CH_COLON: begin
				id_emit = 1'b1;
				id_res.token_kind = TK_COLON;
			end
			CH_QUOTE: id_mode = M_STR;
			CH_LOW_T: begin
				id_mode = M_KEY;
				id_ksel = KW_TRUE;
				id_klet = 3'd1;
			end
			CH_LOW_F: begin
				id_mode = M_KEY;
				id_ksel = KW_FALSE;
				id_klet = 3'd1;
			end
			CH_LOW_N: begin
				id_mode = M_KEY;
				id_ksel = KW_NULL;
				id_klet = 3'd1;
			end
			CH_MINUS: id_mode = M_SIGN;
			CH_ZERO: id_mode = M_ZERO;
			CH_SPACE, CH_TAB, CH_CR, CH_FF: id_mode = M_IDLE;
			CH_LF: id_nl = 1'b1;
			default: begin
				if (c inside {[CH_ONE:CH_NINE]}) begin
					id_mode = M_INT;
				end else begin
					id_emit = 1'b1;
					id_fail = 1'b1;
					id_res  = make_error(ERR_UNEXPECTED, pos32, pos32, line32);
				end
			end
		endcase
	end

	always_comb begin
		n_mode   = mode_q;
		n_pos    = pos_q;
		n_line   = line_q;
		n_tstart = tstart_q;
		n_tline  = tline_q;
		n_ksel   = ksel_q;
		n_klet   = klet_q;
		n_halt   = halt_q;
		r0       = make_token(TK_LBRACE, pos32, pos32, line32);
		r1       = make_token(TK_LBRACE, pos32, pos32, line32);
		cnt      = 2'd0;
		use_idle = 1'b0;
		if (!halt_q && item.end_of_input) begin
			case (mode_q)
				M_STR, M_ESC: begin
					r0     = make_error(ERR_EOF_STRING, tstart32, pos32, line32);
					cnt    = 2'd1;
					n_halt = 1'b1;
				end
				M_SIGN: begin
					r0     = make_error(ERR_DIGIT, tstart32, pos32, line32);
					cnt    = 2'd1;
					n_halt = 1'b1;
				end
				M_KEY: begin
					r0     = make_error(ERR_KEYWORD, tstart32, pos32, line32);
					cnt    = 2'd1;
					n_halt = 1'b1;
				end
				M_IDLE: cnt = 2'd0;
				default: begin
					r0  = make_token(TK_NUMBER, tstart32, prev32, tline32);
					cnt = 2'd1;
				end
			endcase
			if (!n_halt) begin
				if (cnt == 2'd0) begin
					r0 = make_token(TK_END, pos32, pos32, line32);
				end else begin
					r1 = make_token(TK_END, pos32, pos32, line32);
				end
				cnt      = cnt + 2'd1;
				n_mode   = M_IDLE;
				n_pos    = '0;
				n_line   = LINE_BITS'(1);
				n_tstart = '0;
				n_tline  = LINE_BITS'(1);
				n_ksel   = KW_TRUE;
				n_klet   = 3'd0;
			end
		end else if (!halt_q) begin
			n_pos = (pos_q != '1) ? pos_q + POSITION_BITS'(1) : pos_q;
			case (mode_q)
				M_IDLE: use_idle = 1'b1;
				M_STR: begin
					if (c == CH_QUOTE) begin
						r0     = make_token(TK_STRING, tstart32, pos32, tline32);
						cnt    = 2'd1;
						n_mode = M_IDLE;
					end else if (c == CH_BSLASH) begin
						n_mode = M_ESC;
					end
				end
				M_ESC: n_mode = M_STR;
				M_KEY: begin
					if (klet_q >= kw_len(ksel_q) || kw_char(ksel_q, klet_q) != c) begin
						r0     = make_error(ERR_KEYWORD, tstart32, pos32, line32);
						cnt    = 2'd1;
						n_halt = 1'b1;
					end else begin
						n_klet = klet_inc;
						if (klet_inc == kw_len(ksel_q)) begin
							r0     = make_token(kw_kind(ksel_q), tstart32, pos32, tline32);
							cnt    = 2'd1;
							n_mode = M_IDLE;
							n_klet = 3'd0;
						end
					end
				end
				M_SIGN: begin
					if (c == CH_ZERO) begin
						n_mode = M_ZERO;
					end else if (digit) begin
						n_mode = M_INT;
					end else begin
						r0     = make_error(ERR_DIGIT, tstart32, pos32, line32);
						cnt    = 2'd1;
						n_halt = 1'b1;
					end
				end
				M_ZERO, M_INT, M_FRAC: begin
					if (digit && mode_q != M_ZERO) begin
						n_mode = mode_q;
					end else if (c == CH_DOT && mode_q != M_FRAC) begin
						n_mode = M_FRAC;
					end else if (c == CH_LOW_E || c == CH_UP_E) begin
						n_mode = M_EXP;
					end else begin
						use_idle = 1'b1;
					end
				end
				M_EXP: begin
					if (c == CH_PLUS || c == CH_MINUS || digit) begin
						n_mode = M_EXPD;
					end else begin
						use_idle = 1'b1;
					end
				end
				M_EXPD: begin
					if (!digit) begin
						use_idle = 1'b1;
					end
				end
				default: n_mode = M_IDLE;
			endcase
			if (use_idle) begin
				if (mode_q != M_IDLE) begin
					r0  = make_token(TK_NUMBER, tstart32, prev32, tline32);
					cnt = 2'd1;
				end
				n_tstart = pos_q;
				n_tline  = line_q;
				n_mode   = id_mode;
				n_ksel   = id_ksel;
				n_klet   = id_klet;
				if (id_nl && line_q != '1) begin
					n_line = line_q + LINE_BITS'(1);
				end
				if (id_fail) begin
					n_halt = 1'b1;
				end
				if (id_emit) begin
					if (cnt == 2'd0) begin
						r0 = id_res;
					end else begin
						r1 = id_res;
					end
					cnt = cnt + 2'd1;
				end
			end
		end
		if (cnt == 2'd1) begin
			r0.last_of_run = 1'b1;
		end else if (cnt == 2'd2) begin
			r1.last_of_run = 1'b1;
		end
	end

	assign res.count  = step ? cnt : 2'd0;
	assign res.first  = r0;
	assign res.second = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			line_q   <= LINE_BITS'(1);
			tstart_q <= '0;
			tline_q  <= LINE_BITS'(1);
			ksel_q   <= KW_TRUE;
			klet_q   <= 3'd0;
			halt_q   <= 1'b0;
		end else if (step) begin
			mode_q   <= n_mode;
			pos_q    <= n_pos;
			line_q   <= n_line;
			tstart_q <= n_tstart;
			tline_q  <= n_tline;
			ksel_q   <= n_ksel;
			klet_q   <= n_klet;
			halt_q   <= n_halt;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/jbt_result_fifo.sv
// Small result queue that takes up to two results a cycle and hands out one while the receiver is ready.
`default_nettype none

module jbt_result_fifo import jbt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  lex_out_t push,
	output logic     room,
	jbt_chan_if.source tokens
);

	localparam int unsigned DEPTH = RES_FIFO_DEPTH;
	localparam int unsigned IDX_W = $clog2(DEPTH);

	result_t            mem_q [DEPTH];
	logic [IDX_W-1:0]   wr_q;
	logic [IDX_W-1:0]   rd_q;
	logic [IDX_W:0]     cnt_q;
	logic               pop;

	assign tokens.valid = (cnt_q != '0);
	assign tokens.data  = mem_q[rd_q];
	assign pop          = tokens.valid && tokens.ready;
	assign room         = (cnt_q <= (IDX_W + 1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + IDX_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + IDX_W'(push.count);
			rd_q  <= rd_q + IDX_W'(pop);
			cnt_q <= cnt_q + (IDX_W + 1)'(push.count) - (IDX_W + 1)'(pop);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/json_byte_tokenizer.sv
// Top level of the streaming JSON byte tokenizer.
// The bytes channel carries one request per handshake: a text byte and an
// end-of-input flag. The tokens channel returns results: a token kind with
// its start and end byte positions and line, or an error report.
// A byte is accepted into an input register, lexed by combinational logic
// once the queue has room, and its results are written to a four-entry queue.
// Each byte waits in the input register and its results in the queue before
// they are offered on the tokens channel. While the queue has room one byte
// is taken every cycle; a byte that closes a number and is itself punctuation
// or an unexpected byte, or an end of input after a number, yields two
// results.
// When the receiver stalls, the queue fills and input ready drops once the
// queue holds more than two results; nothing is lost or repeated.
// Reset clears the lexer mode, the byte position to zero and the line count
// to one. An error result halts the block: later bytes are taken but yield
// nothing until reset. End of input outside an unfinished string, lone minus
// sign or keyword emits the end token and restarts the counts as after reset.
`default_nettype none

module json_byte_tokenizer import jbt_pkg::*; #(
	parameter int unsigned POSITION_BITS = POS_BITS_DEF,
	parameter int unsigned LINE_BITS     = LINE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	jbt_chan_if.sink   bytes,
	jbt_chan_if.source tokens
);

	logic     valid_s1;
	item_t    item_s1;
	logic     fire;
	logic     room;
	lex_out_t lex_out;

	assign fire        = valid_s1 && room;
	assign bytes.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			item_s1 <= bytes.data;
		end
	end

	jbt_lex_core #(
		.POSITION_BITS(POSITION_BITS),
		.LINE_BITS    (LINE_BITS)
	) u_lex_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (fire),
		.item  (item_s1),
		.res   (lex_out)
	);

	jbt_result_fifo u_result_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (lex_out),
		.room  (room),
		.tokens(tokens)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/jbt_checker.sv
// Port-level checks of the tokenizer's result channel, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module jbt_checker import jbt_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	logic err_seen;
	logic err_shape;

	assign err_seen  = out_valid && out_data.is_error;
	assign err_shape = out_data.last_of_run && (out_data.token_kind == TK_LBRACE);

	`JBT_ASSERT_NEXT(a_out_valid_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`JBT_ASSERT_NEXT(a_out_data_holds, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	`JBT_ASSERT_SAME(a_error_ends_run, clk, arst_n, err_seen, err_shape)
	`JBT_ASSERT_NEXT(a_halt_after_error, clk, arst_n, err_seen && out_ready, !out_valid)

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(tokens.valid),
	.out_ready(tokens.ready),
	.out_data (tokens.data)
);

`default_nettype wire
